### sv/gbv_pkg.sv
package gbv_pkg;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic [7:0] chan_d;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] blur_a;
    logic [7:0] blur_b;
    logic [7:0] blur_c;
    logic [7:0] blur_d;
    logic       frame_end;
  } out_pix_t;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned NCH    = 4;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned MAX_ROWS = 4096;

  typedef enum logic [CFG_AW-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_CHANS   = 3'd2,
    REG_W_CTR   = 3'd3,
    REG_W_ONE   = 3'd4,
    REG_W_TWO   = 3'd5
  } cfg_reg_t;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [2:0]  CHANS_RST  = 3'd3;
  localparam logic [15:0] W_CTR_RST  = 16'd26386;
  localparam logic [15:0] W_ONE_RST  = 16'd16004;
  localparam logic [15:0] W_TWO_RST  = 16'd3571;

endpackage

### sv/gbv_ram.sv
module gbv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/gbv_mac.sv
module gbv_mac (
  input  logic                                 clk,
  input  logic                                 clr,
  input  logic                                 vld,
  input  logic [31:0]                          w2d,
  input  logic [gbv_pkg::PIX_W-1:0]            pix,
  output logic [gbv_pkg::NCH-1:0][7:0]         sum
);

  logic [gbv_pkg::ACC_W-1:0] acc_r [gbv_pkg::NCH];

  // one tap per cycle while vld is high, all channels in parallel; only bits 39:32 matter
  always_ff @(posedge clk) begin
    for (int c = 0; c < gbv_pkg::NCH; c++) begin
      if (clr) begin
        acc_r[c] <= '0;
      end else if (vld) begin
        acc_r[c] <= acc_r[c] + gbv_pkg::ACC_W'(w2d) * pix[8*c +: 8];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < gbv_pkg::NCH; c++) begin
      sum[c] = acc_r[c][39:32];
    end
  end

endmodule

### sv/gaussian_blur_valid_window_core.sv
// per item: accept, line store read, window shift and write-back, then
// every tap of the window through the single tap multiply-accumulate, a drain
// step and the output load; an item with no result returns to idle after the shift
// one item at a time; the held result does not block the next accept
// sync reset clears control and counters, presets config; datapath and line store kept
module gaussian_blur_valid_window_core #(
  parameter int unsigned RADIUS       = 2,
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gbv_pkg::in_pix_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbv_pkg::out_pix_t             out_data,
  input  logic                          cfg_we,
  input  logic [gbv_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [gbv_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int unsigned DIAM  = 2 * RADIUS + 1;
  localparam int unsigned LINES = 2 * RADIUS;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned KW    = $clog2(DIAM);
  localparam int unsigned PW    = gbv_pkg::PIX_W;
  localparam int unsigned DW    = gbv_pkg::DIM_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [10:0] img_w_r;
  logic [12:0] img_h_r;
  logic [2:0]  nch_r;
  logic [15:0] w_ctr_r, w_one_r, w_two_r;

  logic [CW-1:0]              col_r;
  logic [gbv_pkg::ROW_W-1:0]  row_r;
  logic [PW-1:0]              pix_r;
  logic [PW-1:0]              win_r [DIAM][DIAM];
  logic [KW-1:0]              k_r, m_r;
  logic                       fe_r;
  logic [31:0]                w2d_r;
  logic [PW-1:0]              tap_r;
  logic                       tap_vld_r;
  logic                       out_valid_r;
  gbv_pkg::out_pix_t          out_r;

  logic [LINES*PW-1:0] ram_rdata, ram_wdata;
  logic [gbv_pkg::NCH-1:0][7:0] sum;

  logic [DW-1:0] w_eff, h_eff, col_p1, row_p1;
  logic [2:0]    nch_eff;
  logic          row_end, frame_last, produce, in_fire, out_load;

  function automatic logic [15:0] weight_at(input logic [KW-1:0] idx,
                                            input logic [15:0] wc,
                                            input logic [15:0] w1,
                                            input logic [15:0] w2);
    logic [KW-1:0] d;
    d = (idx >= KW'(RADIUS)) ? idx - KW'(RADIUS) : KW'(RADIUS) - idx;
    if (d == '0) begin
      return wc;
    end else if (d == KW'(1)) begin
      return w1;
    end
    return w2;
  endfunction

  // effective frame size and channel count
  always_comb begin
    if (DW'(img_w_r) < DW'(DIAM)) begin
      w_eff = DW'(DIAM);
    end else if (DW'(img_w_r) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(img_w_r);
    end
    if (img_h_r < DW'(DIAM)) begin
      h_eff = DW'(DIAM);
    end else if (img_h_r > DW'(gbv_pkg::MAX_ROWS)) begin
      h_eff = DW'(gbv_pkg::MAX_ROWS);
    end else begin
      h_eff = img_h_r;
    end
    if (nch_r == 3'd0) begin
      nch_eff = 3'd1;
    end else if (nch_r > 3'(MAX_CHANNELS)) begin
      nch_eff = 3'(MAX_CHANNELS);
    end else begin
      nch_eff = nch_r;
    end
  end

  assign col_p1     = DW'(col_r) + DW'(1);
  assign row_p1     = DW'(row_r) + DW'(1);
  assign row_end    = col_p1 >= w_eff;
  assign frame_last = row_end && (row_p1 >= h_eff);
  assign produce    = (DW'(row_r) >= DW'(LINES)) && (DW'(col_r) >= DW'(LINES));

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // one column of the line store per word; line k sits at bits k*32
  always_comb begin
    for (int k = 0; k < LINES - 1; k++) begin
      ram_wdata[k*PW +: PW] = ram_rdata[(k+1)*PW +: PW];
    end
    ram_wdata[(LINES-1)*PW +: PW] = pix_r;
  end

  // read issued at accept, written back in the shift cycle; the next read
  // cannot start before that, so no forwarding is needed
  gbv_ram #(
    .WIDTH(LINES * PW),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (state_r == S_SHIFT),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  gbv_mac u_mac (
    .clk (clk),
    .clr (state_r == S_SHIFT),
    .vld (tap_vld_r),
    .w2d (w2d_r),
    .pix (tap_r),
    .sum (sum)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) begin
                 state_nxt = S_READ;
               end
      S_READ:  state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = produce ? S_MAC : S_IDLE;
      S_MAC:   if (k_r == KW'(DIAM - 1) && m_r == KW'(DIAM - 1)) begin
                 state_nxt = S_DRAIN;
               end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  if (out_load) begin
                 state_nxt = S_IDLE;
               end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      img_w_r     <= gbv_pkg::WIDTH_RST;
      img_h_r     <= gbv_pkg::HEIGHT_RST;
      nch_r       <= gbv_pkg::CHANS_RST;
      w_ctr_r     <= gbv_pkg::W_CTR_RST;
      w_one_r     <= gbv_pkg::W_ONE_RST;
      w_two_r     <= gbv_pkg::W_TWO_RST;
      col_r       <= '0;
      row_r       <= '0;
      k_r         <= '0;
      m_r         <= '0;
      tap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tap_vld_r <= (state_r == S_MAC);
      if (cfg_we) begin
        unique case (cfg_addr)
          gbv_pkg::REG_WIDTH:  img_w_r <= cfg_wdata[10:0];
          gbv_pkg::REG_HEIGHT: img_h_r <= cfg_wdata[12:0];
          gbv_pkg::REG_CHANS:  nch_r   <= cfg_wdata[2:0];
          gbv_pkg::REG_W_CTR:  w_ctr_r <= cfg_wdata;
          gbv_pkg::REG_W_ONE:  w_one_r <= cfg_wdata;
          gbv_pkg::REG_W_TWO:  w_two_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_SHIFT) begin
        k_r <= '0;
        m_r <= '0;
        if (row_end) begin
          col_r <= '0;
          row_r <= frame_last ? '0 : row_p1[gbv_pkg::ROW_W-1:0];
        end else begin
          col_r <= col_p1[CW-1:0];
        end
      end else if (state_r == S_MAC) begin
        if (m_r == KW'(DIAM - 1)) begin
          m_r <= '0;
          k_r <= k_r + KW'(1);
        end else begin
          m_r <= m_r + KW'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // channel a in the low byte
    if (in_fire) begin
      pix_r <= {in_data.chan_d, in_data.chan_c, in_data.chan_b, in_data.chan_a};
    end
    if (state_r == S_SHIFT) begin
      fe_r <= frame_last;
      for (int k = 0; k < DIAM; k++) begin
        for (int m = 0; m < DIAM - 1; m++) begin
          win_r[k][m] <= win_r[k][m+1];
        end
      end
      for (int k = 0; k < LINES; k++) begin
        win_r[k][DIAM-1] <= ram_rdata[k*PW +: PW];
      end
      win_r[LINES][DIAM-1] <= pix_r;
    end
    w2d_r <= weight_at(k_r, w_ctr_r, w_one_r, w_two_r) *
             weight_at(m_r, w_ctr_r, w_one_r, w_two_r);
    tap_r <= win_r[k_r][m_r];
    if (out_load) begin
      out_r.blur_a    <= sum[0];
      out_r.blur_b    <= (nch_eff > 3'd1) ? sum[1] : 8'd0;
      out_r.blur_c    <= (nch_eff > 3'd2) ? sum[2] : 8'd0;
      out_r.blur_d    <= (nch_eff > 3'd3) ? sum[3] : 8'd0;
      out_r.frame_end <= fe_r;
    end
  end

endmodule

### sv/gbv_checker.sv
module gbv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input gbv_pkg::out_pix_t out_data
);

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat while busy");

  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without work");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind gaussian_blur_valid_window_core gbv_checker u_gbv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### verif/tb_gaussian_blur_valid_window_core.sv
`timescale 1ns / 100ps

module tb_gaussian_blur_valid_window_core;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  gbv_pkg::in_pix_t  in_data;
  logic     out_valid;
  logic     out_ready;
  gbv_pkg::out_pix_t out_data;
  logic     cfg_we;
  logic [gbv_pkg::CFG_AW-1:0] cfg_addr;
  logic [gbv_pkg::CFG_DW-1:0] cfg_wdata;

  gaussian_blur_valid_window_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow of the configuration
  logic [10:0] sh_width;
  logic [12:0] sh_height;
  logic [2:0]  sh_chans;
  logic [15:0] sh_wctr, sh_wone, sh_wtwo;

  // shadow of the blur state
  logic [31:0] line_mem [4][1024];
  logic [31:0] win [5][5];
  int unsigned col_cnt, row_cnt;

  gbv_pkg::out_pix_t blur_pending[$];
  int          err_cnt;
  int          pix_sent;
  int          blur_seen;
  int          frame_cnt;
  bit          idle_on;
  int          rx_hold;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint unsigned tap_weight(int k);
    int d;
    d = (k >= 2) ? k - 2 : 2 - k;
    if (d == 0) return sh_wctr;
    if (d == 1) return sh_wone;
    return sh_wtwo;
  endfunction

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the blur shadow by one pixel, queue a blurred pixel if one is due
  task automatic blur_predict(gbv_pkg::in_pix_t p);
    int unsigned w, h, nch, col, row;
    logic [31:0] pix;
    longint unsigned acc;
    gbv_pkg::out_pix_t o;
    logic [7:0] chv [4];
    w   = clamp_u(sh_width, 5, 1024);
    h   = clamp_u(sh_height, 5, 4096);
    nch = clamp_u(sh_chans, 1, 4);
    col = col_cnt % 1024;
    row = row_cnt % 4096;
    pix = {p.chan_d, p.chan_c, p.chan_b, p.chan_a};
    for (int k = 0; k < 5; k++)
      for (int m = 0; m < 4; m++)
        win[k][m] = win[k][m+1];
    for (int k = 0; k < 4; k++)
      win[k][4] = line_mem[k][col];
    win[4][4] = pix;
    for (int k = 0; k < 3; k++)
      line_mem[k][col] = line_mem[k+1][col];
    line_mem[3][col] = pix;
    if (row >= 4 && col >= 4) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        if (c < nch) begin
          for (int k = 0; k < 5; k++)
            for (int m = 0; m < 5; m++)
              acc += tap_weight(k) * tap_weight(m) * ((win[k][m] >> (8 * c)) & 32'hFF);
        end
        chv[c] = acc[39:32];
      end
      o.blur_a = chv[0];
      o.blur_b = chv[1];
      o.blur_c = chv[2];
      o.blur_d = chv[3];
      o.frame_end = (col + 1 >= w && row + 1 >= h);
      blur_pending = {blur_pending, o};
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  task automatic send_pixel(gbv_pkg::in_pix_t p);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    blur_predict(p);
    pix_sent++;
  endtask

  task automatic cfg_write(gbv_pkg::cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      gbv_pkg::REG_WIDTH:  sh_width  = val[10:0];
      gbv_pkg::REG_HEIGHT: sh_height = val[12:0];
      gbv_pkg::REG_CHANS:  sh_chans  = val[2:0];
      gbv_pkg::REG_W_CTR:  sh_wctr   = val;
      gbv_pkg::REG_W_ONE:  sh_wone   = val;
      gbv_pkg::REG_W_TWO:  sh_wtwo   = val;
      default: ;
    endcase
  endtask

  // wait for every blurred pixel, then let a no-result pixel finish
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (blur_pending.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic gbv_pkg::in_pix_t make_pixel(int mode);
    gbv_pkg::in_pix_t p;
    case (mode)
      1:       p = '1;
      2:       p = '0;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic run_frame(logic [15:0] w, logic [15:0] h, logic [15:0] ch,
                           logic [15:0] wc, logic [15:0] w1, logic [15:0] w2, int mode);
    int unsigned npix;
    cfg_write(gbv_pkg::REG_WIDTH, w);
    cfg_write(gbv_pkg::REG_HEIGHT, h);
    cfg_write(gbv_pkg::REG_CHANS, ch);
    cfg_write(gbv_pkg::REG_W_CTR, wc);
    cfg_write(gbv_pkg::REG_W_ONE, w1);
    cfg_write(gbv_pkg::REG_W_TWO, w2);
    npix = clamp_u(sh_width, 5, 1024) * clamp_u(sh_height, 5, 4096);
    for (int unsigned i = 0; i < npix; i++)
      send_pixel(make_pixel(mode));
    drain();
    frame_cnt++;
  endtask

  task automatic test_extremes;
    // saturated weights with all-ones and then all-zero pixels: the all-ones sums wrap
    run_frame(5, 5, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    run_frame(5, 5, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
    // out-of-range sizes and channel counts are clamped
    run_frame(0, 0, 0, gbv_pkg::W_CTR_RST, gbv_pkg::W_ONE_RST, gbv_pkg::W_TWO_RST, 0);
    run_frame(6, 7, 7, 0, 0, 0, 0);
    run_frame(5, 6, 2, 16'hFFFF, 0, 16'h8000, 0);
  endtask

  task automatic test_large_frames;
    run_frame(40, 6, 4, gbv_pkg::W_CTR_RST, gbv_pkg::W_ONE_RST, gbv_pkg::W_TWO_RST, 0);
  endtask

  task automatic test_random_frames(int target);
    int start;
    start = pix_sent;
    while (pix_sent - start < target)
      run_frame(16'($urandom_range(5, 12)), 16'($urandom_range(5, 10)),
                16'($urandom_range(1, 4)), 16'($urandom), 16'($urandom), 16'($urandom),
                ($urandom_range(0, 9) == 0) ? 1 : 0);
  endtask

  task automatic test_backpressure;
    fork
      rx_hold = 400;
      run_frame(10, 9, 4, gbv_pkg::W_CTR_RST, gbv_pkg::W_ONE_RST, gbv_pkg::W_TWO_RST, 0);
    join
  endtask

  // receiver: random stall bursts, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    gbv_pkg::out_pix_t e;
    if (rst_n && out_valid && out_ready) begin
      if (blur_pending.size() == 0) begin
        $error("unexpected output beat %h", out_data);
        err_cnt++;
      end else begin
        e = blur_pending.pop_front();
        blur_seen++;
        if (out_data.blur_a !== e.blur_a) begin
          $error("blur_a exp %h got %h", e.blur_a, out_data.blur_a);
          err_cnt++;
        end
        if (out_data.blur_b !== e.blur_b) begin
          $error("blur_b exp %h got %h", e.blur_b, out_data.blur_b);
          err_cnt++;
        end
        if (out_data.blur_c !== e.blur_c) begin
          $error("blur_c exp %h got %h", e.blur_c, out_data.blur_c);
          err_cnt++;
        end
        if (out_data.blur_d !== e.blur_d) begin
          $error("blur_d exp %h got %h", e.blur_d, out_data.blur_d);
          err_cnt++;
        end
        if (out_data.frame_end !== e.frame_end) begin
          $error("frame_end exp %b got %b", e.frame_end, out_data.frame_end);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    err_cnt   = 0;
    pix_sent  = 0;
    blur_seen = 0;
    frame_cnt = 0;
    rx_hold   = 0;
    idle_on   = 1'b1;
    sh_width  = gbv_pkg::WIDTH_RST;
    sh_height = gbv_pkg::HEIGHT_RST;
    sh_chans  = gbv_pkg::CHANS_RST;
    sh_wctr   = gbv_pkg::W_CTR_RST;
    sh_wone   = gbv_pkg::W_ONE_RST;
    sh_wtwo   = gbv_pkg::W_TWO_RST;
    col_cnt   = 0;
    row_cnt   = 0;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 1024; i++)
        line_mem[k][i] = '0;
    for (int k = 0; k < 5; k++)
      for (int m = 0; m < 5; m++)
        win[k][m] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_random_frames(600);
    test_backpressure();
    test_large_frames();
    idle_on = 1'b0;
    test_random_frames(200);

    drain();
    $display("covered %0d frames: %0d pixels in, %0d blurred pixels checked",
             frame_cnt, pix_sent, blur_seen);
    $display("clamped and random sizes up to 40 wide, 1 to 4 channels, wrapped sums, long stalls");
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
